FILE: design/qrs_pkg.sv
package qrs_pkg;

    // Fixed result format and internal widths
    localparam int ROOT_W   = 32;          // result fields, Q16.16
    localparam int RAD_W    = 64;          // square root radicand
    localparam int SQ_W     = 32;          // square root result
    localparam int SQ_REM_W = 35;          // sqrt partial remainder
    localparam int BQ_W     = 34;          // -b * 2^E
    localparam int DEN_W    = 33;          // |a| * 2^(E+1)
    localparam int NUM_W    = 49;          // |numerator| * 2^16
    localparam int DIV_REM_W = 34;         // divider partial remainder
    localparam int LANES    = 3;           // first root, second root, imaginary part
    localparam int OUT_FRAC = 16;

    localparam int LANE_N1   = 0;
    localparam int LANE_N2   = 1;
    localparam int LANE_IMAG = 2;

    localparam logic [1:0] COUNT_COMPLEX  = 2'd0;
    localparam logic [1:0] COUNT_DOUBLE   = 2'd1;
    localparam logic [1:0] COUNT_DISTINCT = 2'd2;

    typedef struct packed {
        logic signed [BQ_W-1:0] bq;
        logic [DEN_W-1:0]       den_mag;
        logic                   den_neg;
        logic                   d_neg;
        logic                   d_zero;
        logic                   degen;
    } sq_side_t;

    typedef struct packed {
        logic [LANES-1:0] q_neg;
        logic [1:0]       count;
        logic             degen;
    } dv_side_t;

endpackage

FILE: design/qrs_if.sv
interface coef_if #(parameter int COEF_WIDTH = 16);
    logic                         valid;
    logic                         ready;
    logic signed [COEF_WIDTH-1:0] coef_a;
    logic signed [COEF_WIDTH-1:0] coef_b;
    logic signed [COEF_WIDTH-1:0] coef_c;

    modport source (output valid, coef_a, coef_b, coef_c, input ready);
    modport sink   (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

interface root_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] first_root_real;
    logic signed [31:0] second_root_real;
    logic signed [31:0] imag_part;
    logic [1:0]         real_root_count;
    logic               degenerate;

    modport source (output valid, first_root_real, second_root_real, imag_part,
                    real_root_count, degenerate, input ready);
    modport sink   (input valid, first_root_real, second_root_real, imag_part,
                    real_root_count, degenerate, output ready);
endinterface

FILE: design/qrs_sqrt.sv
module qrs_sqrt
    import qrs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [RAD_W-1:0] rad,
    input  sq_side_t         side_in,
    output logic             out_valid,
    output logic [SQ_W-1:0]  root,
    output sq_side_t         side_out
);

    // one result bit per stage, two radicand bits consumed per stage
    logic [SQ_W-1:0]     valid_reg;
    logic [RAD_W-1:0]    rad_reg  [SQ_W];
    logic [SQ_REM_W-1:0] rem_reg  [SQ_W];
    logic [SQ_W-1:0]     root_reg [SQ_W];
    sq_side_t            side_reg [SQ_W];

    genvar i;
    for (i = 0; i < SQ_W; i++)
    begin : g_stage
        logic                v_in;
        logic [RAD_W-1:0]    rad_in;
        logic [SQ_REM_W-1:0] rem_in;
        logic [SQ_W-1:0]     root_in;
        sq_side_t            side_i;
        logic [SQ_REM_W-1:0] rem_sh;
        logic [SQ_REM_W-1:0] trial;

        if (i == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign rad_in  = rad;
            assign rem_in  = '0;
            assign root_in = '0;
            assign side_i  = side_in;
        end
        else
        begin : g_next
            assign v_in    = valid_reg[i-1];
            assign rad_in  = rad_reg[i-1];
            assign rem_in  = rem_reg[i-1];
            assign root_in = root_reg[i-1];
            assign side_i  = side_reg[i-1];
        end

        assign rem_sh = {rem_in[SQ_REM_W-3:0], rad_in[RAD_W-1:RAD_W-2]};
        assign trial  = {1'b0, root_in, 2'b01};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i] <= 1'b0;
            else if (en)
                valid_reg[i] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[i]  <= {rad_in[RAD_W-3:0], 2'b00};
                side_reg[i] <= side_i;
                if (rem_sh >= trial)
                begin
                    rem_reg[i]  <= rem_sh - trial;
                    root_reg[i] <= {root_in[SQ_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[i]  <= rem_sh;
                    root_reg[i] <= {root_in[SQ_W-2:0], 1'b0};
                end
            end
        end
    end

    assign out_valid = valid_reg[SQ_W-1];
    assign root      = root_reg[SQ_W-1];
    assign side_out  = side_reg[SQ_W-1];

endmodule

FILE: design/qrs_div.sv
module qrs_div
    import qrs_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [LANES-1:0][NUM_W-1:0] num,
    input  logic [DEN_W-1:0]            den,
    input  dv_side_t                    side_in,
    output logic                        out_valid,
    output logic [LANES-1:0][NUM_W-1:0] quo,
    output dv_side_t                    side_out
);

    // restoring division, one quotient bit per stage; the dividend shifts out
    // the top while quotient bits shift in at the bottom
    logic [NUM_W-1:0]                      valid_reg;
    logic [LANES-1:0][NUM_W-1:0]           nq_reg   [NUM_W];
    logic [LANES-1:0][DIV_REM_W-1:0]       rem_reg  [NUM_W];
    logic [DEN_W-1:0]                      den_reg  [NUM_W];
    dv_side_t                              side_reg [NUM_W];

    genvar i;
    for (i = 0; i < NUM_W; i++)
    begin : g_stage
        logic                            v_in;
        logic [LANES-1:0][NUM_W-1:0]     nq_in;
        logic [LANES-1:0][DIV_REM_W-1:0] rem_in;
        logic [DEN_W-1:0]                den_in;
        dv_side_t                        side_i;
        logic [LANES-1:0][NUM_W-1:0]     nq_next;
        logic [LANES-1:0][DIV_REM_W-1:0] rem_next;

        if (i == 0)
        begin : g_first
            assign v_in   = in_valid;
            assign nq_in  = num;
            assign rem_in = '0;
            assign den_in = den;
            assign side_i = side_in;
        end
        else
        begin : g_next
            assign v_in   = valid_reg[i-1];
            assign nq_in  = nq_reg[i-1];
            assign rem_in = rem_reg[i-1];
            assign den_in = den_reg[i-1];
            assign side_i = side_reg[i-1];
        end

        always_comb
        begin
            for (int l = 0; l < LANES; l++)
            begin
                logic [DIV_REM_W-1:0] rem_sh;
                rem_sh = {rem_in[l][DIV_REM_W-2:0], nq_in[l][NUM_W-1]};
                if (rem_sh >= {1'b0, den_in})
                begin
                    rem_next[l] = rem_sh - {1'b0, den_in};
                    nq_next[l]  = {nq_in[l][NUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next[l] = rem_sh;
                    nq_next[l]  = {nq_in[l][NUM_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i] <= 1'b0;
            else if (en)
                valid_reg[i] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                nq_reg[i]   <= nq_next;
                rem_reg[i]  <= rem_next;
                den_reg[i]  <= den_in;
                side_reg[i] <= side_i;
            end
        end
    end

    assign out_valid = valid_reg[NUM_W-1];
    assign quo       = nq_reg[NUM_W-1];
    assign side_out  = side_reg[NUM_W-1];

endmodule

FILE: design/quadratic_root_solver_unit.sv
// Quadratic root solver, fully pipelined.
// Pipeline: 2 setup stages, 32 square root stages, 1 numerator stage,
// 49 divider stages and 1 output stage.
// Throughput: one coefficient set per cycle; a stalled output freezes the whole pipe.
// Reset: asynchronous active-low rst_n clears all valid bits; data is not reset.
module quadratic_root_solver_unit
    import qrs_pkg::*;
#(
    parameter int COEF_WIDTH = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    coef_if.sink                  coefs,
    root_if.source                roots
);

    // sqrt keeps E extra fraction bits so the root always spans 32 bits
    localparam int E     = 31 - COEF_WIDTH;
    localparam int PW    = 2 * COEF_WIDTH;       // product width
    localparam int DW    = 2 * COEF_WIDTH + 3;   // discriminant width

    // global advance: every stage moves when the output slot is free
    logic en;
    logic out_valid_reg;
    assign en          = !out_valid_reg || roots.ready;
    assign coefs.ready = en;

    // ---------------- stage A: products ----------------
    logic                         a_valid_reg;
    logic signed [COEF_WIDTH-1:0] a_a_reg;
    logic signed [COEF_WIDTH-1:0] a_b_reg;
    logic signed [PW-1:0]         a_bb_reg;
    logic signed [PW-1:0]         a_ac_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (en)
            a_valid_reg <= coefs.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_a_reg  <= coefs.coef_a;
            a_b_reg  <= coefs.coef_b;
            a_bb_reg <= coefs.coef_b * coefs.coef_b;
            a_ac_reg <= coefs.coef_a * coefs.coef_c;
        end
    end

    // ---------------- stage B: discriminant, radicand, scaling ----------------
    logic signed [DW-1:0]   d_next;
    logic [DW-2:0]          mag_next;
    logic [DEN_W-1:0]       a_mag;
    sq_side_t               b_side_next;
    logic                   b_valid_reg;
    logic [RAD_W-1:0]       b_rad_reg;
    sq_side_t               b_side_reg;

    always_comb
    begin
        d_next   = DW'(a_bb_reg) - (DW'(a_ac_reg) <<< 2);
        mag_next = d_next[DW-1] ? (DW-1)'(-d_next) : d_next[DW-2:0];
        a_mag    = a_a_reg[COEF_WIDTH-1] ? DEN_W'(-(DEN_W'(a_a_reg)))
                                         : DEN_W'(a_a_reg);
        b_side_next.bq      = -(BQ_W'(a_b_reg) <<< E);
        b_side_next.den_mag = a_mag << (E + 1);
        b_side_next.den_neg = a_a_reg[COEF_WIDTH-1];
        b_side_next.d_neg   = d_next[DW-1];
        b_side_next.d_zero  = (d_next == '0);
        b_side_next.degen   = (a_a_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (en)
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_rad_reg  <= RAD_W'(mag_next) << (2 * E);
            b_side_reg <= b_side_next;
        end
    end

    // ---------------- square root ----------------
    logic            sq_valid;
    logic [SQ_W-1:0] sq_root;
    sq_side_t        sq_side;

    qrs_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (b_valid_reg),
        .rad      (b_rad_reg),
        .side_in  (b_side_reg),
        .out_valid(sq_valid),
        .root     (sq_root),
        .side_out (sq_side)
    );

    // ---------------- stage C: signed numerators -> magnitudes ----------------
    logic signed [BQ_W-1:0]      n_val [LANES];
    logic [LANES-1:0][NUM_W-1:0] c_num_next;
    dv_side_t                    c_side_next;
    logic                        c_valid_reg;
    logic [LANES-1:0][NUM_W-1:0] c_num_reg;
    logic [DEN_W-1:0]            c_den_reg;
    dv_side_t                    c_side_reg;

    always_comb
    begin
        logic signed [BQ_W-1:0] s_ext;
        s_ext = BQ_W'(sq_root);
        if (sq_side.d_neg)
        begin
            n_val[LANE_N1]   = sq_side.bq;
            n_val[LANE_N2]   = sq_side.bq;
            n_val[LANE_IMAG] = s_ext;
            c_side_next.count = COUNT_COMPLEX;
        end
        else
        begin
            n_val[LANE_N1]   = sq_side.bq - s_ext;
            n_val[LANE_N2]   = sq_side.bq + s_ext;
            n_val[LANE_IMAG] = '0;
            c_side_next.count = sq_side.d_zero ? COUNT_DOUBLE : COUNT_DISTINCT;
        end
        for (int l = 0; l < LANES; l++)
        begin
            logic [BQ_W-1:0] n_abs;
            n_abs = n_val[l][BQ_W-1] ? BQ_W'(-n_val[l]) : BQ_W'(n_val[l]);
            c_num_next[l]        = NUM_W'(n_abs) << OUT_FRAC;
            c_side_next.q_neg[l] = n_val[l][BQ_W-1] ^ sq_side.den_neg;
        end
        c_side_next.degen = sq_side.degen;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_valid_reg <= 1'b0;
        else if (en)
            c_valid_reg <= sq_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_num_reg  <= c_num_next;
            c_den_reg  <= sq_side.den_mag;
            c_side_reg <= c_side_next;
        end
    end

    // ---------------- division, three lanes share the divisor ----------------
    logic                        dv_valid;
    logic [LANES-1:0][NUM_W-1:0] dv_quo;
    dv_side_t                    dv_side;

    qrs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (c_valid_reg),
        .num      (c_num_reg),
        .den      (c_den_reg),
        .side_in  (c_side_reg),
        .out_valid(dv_valid),
        .quo      (dv_quo),
        .side_out (dv_side)
    );

    // ---------------- output: sign, saturate, degenerate override ----------------
    logic [LANES-1:0][ROOT_W-1:0] sat_next;
    logic [LANES-1:0][ROOT_W-1:0] res_reg;
    logic [1:0]                   count_reg;
    logic                         degen_reg;

    localparam logic [NUM_W-1:0] POS_LIMIT = NUM_W'(32'h7fff_ffff);
    localparam logic [NUM_W-1:0] NEG_LIMIT = NUM_W'(33'h0_8000_0000);

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            if (dv_side.degen)
                sat_next[l] = '0;
            else if (!dv_side.q_neg[l])
                sat_next[l] = (dv_quo[l] > POS_LIMIT) ? 32'h7fff_ffff
                                                      : dv_quo[l][ROOT_W-1:0];
            else
                sat_next[l] = (dv_quo[l] > NEG_LIMIT) ? 32'h8000_0000
                                                      : -dv_quo[l][ROOT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg   <= sat_next;
            count_reg <= dv_side.degen ? COUNT_COMPLEX : dv_side.count;
            degen_reg <= dv_side.degen;
        end
    end

    assign roots.valid            = out_valid_reg;
    assign roots.first_root_real  = res_reg[LANE_N1];
    assign roots.second_root_real = res_reg[LANE_N2];
    assign roots.imag_part        = res_reg[LANE_IMAG];
    assign roots.real_root_count  = count_reg;
    assign roots.degenerate       = degen_reg;

endmodule

FILE: tb/sv/qrs_root_checker.sv
`timescale 1ns / 100ps

module qrs_root_checker
    import qrs_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    coef_if.sink   coefs_mon,
    root_if.sink   roots_mon,
    output int     fail_count,
    output int     pending_roots
);

    typedef struct packed {
        logic signed [31:0] r1;
        logic signed [31:0] r2;
        logic signed [31:0] im;
        logic [1:0]         cnt;
        logic               degen;
    } roots_t;

    roots_t expected_roots[$];
    int     mismatch_count;

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic roots_t solve_roots(logic signed [15:0] ca, logic signed [15:0] cb,
                                           logic signed [15:0] cc);
        roots_t          r;
        longint          a, b, c, d, s, bq, den, n1, n2, imv;
        longint unsigned mag;
        a = ca;
        b = cb;
        c = cc;
        r = '0;
        if (a == 0)
        begin
            r.degen = 1'b1;
            return r;
        end
        d   = b * b - 4 * a * c;
        mag = (d < 0) ? -d : d;
        s   = int_sqrt(mag << 30);
        bq  = -b * 32768;
        den = a * 65536;
        if (d >= 0)
        begin
            n1    = bq - s;
            n2    = bq + s;
            imv   = 0;
            r.cnt = (d == 0) ? COUNT_DOUBLE : COUNT_DISTINCT;
        end
        else
        begin
            n1    = bq;
            n2    = bq;
            imv   = (s * 65536) / den;
            r.cnt = COUNT_COMPLEX;
        end
        r.r1 = clamp32((n1 * 65536) / den);
        r.r2 = clamp32((n2 * 65536) / den);
        r.im = clamp32(imv);
        return r;
    endfunction

    assign fail_count = mismatch_count;

    always @(posedge clk or negedge rst_n)
    begin
        roots_t exp_r;
        roots_t got_r;
        if (!rst_n)
        begin
            mismatch_count = 0;
            expected_roots.delete();
            pending_roots = 0;
        end
        else
        begin
            if (coefs_mon.valid && coefs_mon.ready)
                expected_roots.push_back(solve_roots(coefs_mon.coef_a, coefs_mon.coef_b,
                                                     coefs_mon.coef_c));
            if (roots_mon.valid && roots_mon.ready)
            begin
                got_r = {roots_mon.first_root_real, roots_mon.second_root_real,
                         roots_mon.imag_part, roots_mon.real_root_count,
                         roots_mon.degenerate};
                if (expected_roots.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected root transfer: %h", got_r);
                end
                else
                begin
                    exp_r = expected_roots.pop_front();
                    if (got_r !== exp_r)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"root mismatch: exp r1=%0d r2=%0d im=%0d n=%0d dg=%0d",
                                      " got r1=%0d r2=%0d im=%0d n=%0d dg=%0d"},
                                     exp_r.r1, exp_r.r2, exp_r.im, exp_r.cnt, exp_r.degen,
                                     got_r.r1, got_r.r2, got_r.im, got_r.cnt, got_r.degen);
                    end
                end
            end
            pending_roots = expected_roots.size();
        end
    end

endmodule

FILE: tb/sv/tb_quadratic_root_solver_unit.sv
`timescale 1ns / 100ps

module tb_quadratic_root_solver_unit;
    import qrs_pkg::*;

    localparam int RANDOM_SETS = 1930;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 120;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_roots;
    int   cycle_count;
    bit   hold_off;

    coef_if #(.COEF_WIDTH(16)) coefs ();
    root_if                    roots ();

    quadratic_root_solver_unit #(.COEF_WIDTH(16)) dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .coefs (coefs.sink),
        .roots (roots.source)
    );

    qrs_root_checker checker_i
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .coefs_mon     (coefs.sink),
        .roots_mon     (roots.sink),
        .fail_count    (fail_count),
        .pending_roots (pending_roots)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 55)
            return 0;
        if (p < 93)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // Random coefficient: full range, or small values that give moderate roots.
    function automatic logic [15:0] rand_coef();
        int p;
        p = $urandom_range(9);
        if (p < 5)
            return 16'($urandom());
        if (p < 8)
            return 16'($signed($urandom_range(2048)) - 1024);
        return 16'($signed($urandom_range(64)) - 32);
    endfunction

    // Watchdog on total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("quadratic_root_solver_unit regression: fail");
            $finish;
        end
    end

    // One coefficient-set transfer; holds valid until the block takes it.
    task automatic send_coefs(logic [15:0] a, logic [15:0] b, logic [15:0] c);
        int g;
        g = gap_len();
        repeat (g)
        begin
            coefs.valid <= 1'b0;
            @(posedge clk);
        end
        coefs.valid  <= 1'b1;
        coefs.coef_a <= a;
        coefs.coef_b <= b;
        coefs.coef_c <= c;
        @(posedge clk);
        while (!coefs.ready)
            @(posedge clk);
    endtask

    // Receiver side: random stalls plus one long hold-off to back the pipe up.
    initial
    begin
        int g;
        roots.ready = 1'b0;
        hold_off    = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                roots.ready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            g = gap_len();
            if (g > 0)
            begin
                roots.ready <= 1'b0;
                repeat (g - 1) @(posedge clk);
                @(posedge clk);
            end
            roots.ready <= 1'b1;
        end
    end

    initial
    begin
        logic [15:0] edge_vals[6];
        cycle_count  = 0;
        rst_n        = 1'b0;
        coefs.valid  = 1'b0;
        coefs.coef_a = '0;
        coefs.coef_b = '0;
        coefs.coef_c = '0;
        edge_vals    = '{16'h8000, 16'h7fff, 16'h0000, 16'h0001, 16'hffff, 16'h0100};
        repeat (5) @(posedge clk);
        rst_n = 1'b1;

        // Directed: degenerate a, double root, distinct roots, complex pair, extremes.
        send_coefs(16'h0000, 16'h1234, 16'h5678);
        send_coefs(16'h0100, 16'h0400, 16'h0400);
        send_coefs(16'h0100, 16'h0000, 16'hff00);
        send_coefs(16'h0100, 16'h0000, 16'h0100);
        send_coefs(16'hff00, 16'h0200, 16'h0300);
        for (int i = 0; i < 6; i++)
            for (int j = 0; j < 3; j++)
                send_coefs(edge_vals[i], edge_vals[(i + j + 1) % 6], edge_vals[(i + 2 * j) % 6]);

        // Random sets; long receiver hold-off in the middle while we keep sending.
        for (int n = 0; n < RANDOM_SETS; n++)
        begin
            if (n == RANDOM_SETS / 2)
                hold_off = 1'b1;
            send_coefs(rand_coef(), rand_coef(), rand_coef());
        end
        coefs.valid <= 1'b0;

        while (pending_roots != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (fail_count == 0)
            $display("quadratic_root_solver_unit regression: pass");
        else
            $display("quadratic_root_solver_unit regression: fail");
        $finish;
    end

endmodule

FILE: sim.f
design/qrs_pkg.sv
design/qrs_if.sv
design/qrs_sqrt.sv
design/qrs_div.sv
design/quadratic_root_solver_unit.sv
tb/sv/qrs_root_checker.sv
tb/sv/tb_quadratic_root_solver_unit.sv
